[rtl/ile_pkg.sv]
// Shared types and codes for the indexed list engine.
`default_nettype none

package ile_pkg;

  // Request codes carried on req_type.
  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_PUSH     = 3'd1,
    OP_INSERT   = 3'd2,
    OP_POP_TAIL = 3'd3,
    OP_POP_HEAD = 3'd4,
    OP_REMOVE   = 3'd5,
    OP_FIND     = 3'd6,
    OP_CLEAR    = 3'd7
  } op_t;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Commands broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic ins;    // open a gap at the target index and write the key there
    logic rem;    // close the gap at the target index and tap the old item
    logic fnd;    // load the compare flag from the key match
    logic shift;  // move flags and taps one cell toward the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/ile_cell.sv]
// One storage cell of the list chain, with its scan flag and tap lane.
`default_nettype none

module ile_cell #(
  parameter int INDEX      = 0,
  parameter int CNT_W      = 5,
  parameter int ITEM_WIDTH = 32
) (
  input  wire                    clk,
  input  wire                    rst,
  input  ile_pkg::cell_ctrl_t    ctrl,
  input  wire  [CNT_W-1:0]       at,
  input  wire  [CNT_W-1:0]       count,
  input  wire  [ITEM_WIDTH-1:0]  key,
  input  wire  [ITEM_WIDTH-1:0]  left_data,
  input  wire  [ITEM_WIDTH-1:0]  right_data,
  input  wire                    right_flag,
  input  wire  [ITEM_WIDTH-1:0]  right_lane,
  output logic [ITEM_WIDTH-1:0]  data,
  output logic                   flag,
  output logic [ITEM_WIDTH-1:0]  lane
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic above_at;
  logic at_me;
  logic in_list;

  assign above_at = MY_IDX > at;
  assign at_me    = MY_IDX == at;
  assign in_list  = MY_IDX < count;

  // Stored item: key or left neighbor on insert, right neighbor on remove.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (above_at) begin
        data <= left_data;
      end else if (at_me) begin
        data <= key;
      end
    end else if (ctrl.rem) begin
      if (above_at || at_me) begin
        data <= right_data;
      end
    end
  end

  // Scan flag: marks the tapped cell or a match, then walks toward the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctrl.rem) begin
      flag <= at_me;
    end else if (ctrl.fnd) begin
      flag <= in_list && (data == key);
    end else if (ctrl.shift) begin
      flag <= right_flag;
    end
  end

  // Tap lane: carries the removed item toward the head.
  always_ff @(posedge clk) begin
    if (ctrl.rem) begin
      lane <= data;
    end else if (ctrl.shift) begin
      lane <= right_lane;
    end
  end

endmodule

`default_nettype wire

[rtl/indexed_list_engine.sv]
// Top level of the indexed list engine: request decode, count and scan control.
// Append, push, insert, clear and failed requests report in the cycle after acceptance.
// Pop, remove and find report after a scan of flags along the cell chain; the index
// it reaches is at most the length before the request minus one.
// Busy is high during the scan, so no new word is taken until the scan is over.
// Reset (synchronous) empties the list; the receiver cannot stall results.
`default_nettype none

module indexed_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  req_type,
  input  wire  [15:0] position,
  input  wire  [31:0] item_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] item_out,
  output logic [3:0]  found_position,
  output logic [4:0]  list_length
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     scan_cnt;
  logic [IDX_W-1:0]     scan_last;
  logic                 scan_find;

  logic                 accept;
  logic [ITEM_WIDTH-1:0] key;
  ile_pkg::cell_ctrl_t  ctrl;
  logic [CNT_W-1:0]     at;
  logic [CNT_W-1:0]     count_next;
  logic                 imm_done;
  logic [1:0]           imm_status;
  logic                 go_scan;
  logic [IDX_W-1:0]     scan_last_next;
  logic                 scan_stop;
  logic [15:0]          count_wide;
  logic [CNT_W-1:0]     pos_clip;
  logic                 pos_in;

  logic [ITEM_WIDTH-1:0] data_w [CAPACITY];
  logic [ITEM_WIDTH-1:0] lane_w [CAPACITY];
  logic                  flag_w [CAPACITY];

  assign accept     = start && !busy;
  assign busy       = state == S_SCAN;
  assign key        = ITEM_WIDTH'(item_data);
  assign count_wide = 16'(count);
  assign pos_in     = position < count_wide;
  assign pos_clip   = pos_in ? CNT_W'(position) : count;
  assign scan_stop  = flag_w[0] || (scan_cnt == scan_last);

  // Request decode into chain commands and the next count.
  always_comb begin
    ctrl           = '0;
    at             = '0;
    count_next     = count;
    imm_done       = 1'b0;
    imm_status     = ile_pkg::ST_OK;
    go_scan        = 1'b0;
    scan_last_next = '0;
    if (accept) begin
      unique case (ile_pkg::op_t'(req_type))
        ile_pkg::OP_APPEND, ile_pkg::OP_PUSH, ile_pkg::OP_INSERT: begin
          imm_done = 1'b1;
          if (count == CAP_CNT) begin
            imm_status = ile_pkg::ST_FULL;
          end else begin
            ctrl.ins   = 1'b1;
            count_next = count + CNT_W'(1);
            if (ile_pkg::op_t'(req_type) == ile_pkg::OP_APPEND) begin
              at = count;
            end else if (ile_pkg::op_t'(req_type) == ile_pkg::OP_PUSH) begin
              at = '0;
            end else begin
              at = pos_clip;
            end
          end
        end
        ile_pkg::OP_POP_TAIL, ile_pkg::OP_POP_HEAD: begin
          if (count == '0) begin
            imm_done   = 1'b1;
            imm_status = ile_pkg::ST_MISS;
          end else begin
            ctrl.rem   = 1'b1;
            go_scan    = 1'b1;
            count_next = count - CNT_W'(1);
            if (ile_pkg::op_t'(req_type) == ile_pkg::OP_POP_TAIL) begin
              at = count - CNT_W'(1);
            end else begin
              at = '0;
            end
            scan_last_next = IDX_W'(at);
          end
        end
        ile_pkg::OP_REMOVE: begin
          if (!pos_in) begin
            imm_done   = 1'b1;
            imm_status = ile_pkg::ST_MISS;
          end else begin
            ctrl.rem       = 1'b1;
            go_scan        = 1'b1;
            count_next     = count - CNT_W'(1);
            at             = pos_clip;
            scan_last_next = IDX_W'(pos_clip);
          end
        end
        ile_pkg::OP_FIND: begin
          if (count == '0) begin
            imm_done   = 1'b1;
            imm_status = ile_pkg::ST_MISS;
          end else begin
            ctrl.fnd       = 1'b1;
            go_scan        = 1'b1;
            scan_last_next = IDX_W'(count - CNT_W'(1));
          end
        end
        ile_pkg::OP_CLEAR: begin
          imm_done   = 1'b1;
          count_next = '0;
        end
        default: begin
          imm_done = 1'b0;
        end
      endcase
    end else if (state == S_SCAN && !scan_stop) begin
      ctrl.shift = 1'b1;
    end
  end

  // Chain of cells; on insert or remove, data moves one cell in either direction.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left_d;
    logic [ITEM_WIDTH-1:0] right_d;
    logic [ITEM_WIDTH-1:0] right_l;
    logic                  right_f;
    if (i == 0) begin : g_head
      assign left_d = key;
    end else begin : g_mid
      assign left_d = data_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
      assign right_l = '0;
      assign right_f = 1'b0;
    end else begin : g_body
      assign right_d = data_w[i+1];
      assign right_l = lane_w[i+1];
      assign right_f = flag_w[i+1];
    end
    ile_cell #(
      .INDEX      (i),
      .CNT_W      (CNT_W),
      .ITEM_WIDTH (ITEM_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .at         (at),
      .count      (count),
      .key        (key),
      .left_data  (left_d),
      .right_data (right_d),
      .right_flag (right_f),
      .right_lane (right_l),
      .data       (data_w[i]),
      .flag       (flag_w[i]),
      .lane       (lane_w[i])
    );
  end

  // Control state: sequencer, count and scan position.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      done     <= 1'b0;
      scan_cnt <= '0;
    end else begin
      count <= count_next;
      done  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          scan_cnt <= '0;
          if (imm_done) begin
            done <= 1'b1;
          end
          if (go_scan) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_stop) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            scan_cnt <= scan_cnt + IDX_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Scan bookkeeping captured when a request is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      scan_last <= scan_last_next;
      scan_find <= ile_pkg::op_t'(req_type) == ile_pkg::OP_FIND;
    end
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && imm_done) begin
      status         <= imm_status;
      item_out       <= '0;
      found_position <= '0;
      list_length    <= 5'(count_next);
    end else if (state == S_SCAN && scan_stop) begin
      status         <= flag_w[0] ? ile_pkg::ST_OK : ile_pkg::ST_MISS;
      item_out       <= (flag_w[0] && !scan_find) ? 32'(lane_w[0]) : '0;
      found_position <= (flag_w[0] && scan_find) ? 4'(scan_cnt) : '0;
      list_length    <= 5'(count);
    end
  end

  // A result never shows while a scan is still running.
  a_no_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done) else $error("result strobe during scan");

  // The length never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT) else $error("list length beyond capacity");

  // Every accepted request either reports at once or starts a scan.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy)) else $error("request dropped");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status != 2'd3)) else $error("undefined status code");

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the indexed list engine: directed and random word traffic.
`timescale 1ns / 100ps

module testbench;

  localparam int LIST_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SHOWN_MAX   = 10;

  // One request word as the driver presents it.
  typedef struct {
    ile_pkg::op_t op;
    logic [15:0]  pos;
    logic [31:0]  data;
    int           gap;
  } list_req_t;

  // One result word as the engine reports it.
  typedef struct {
    logic [1:0]  status;
    logic [31:0] item;
    logic [3:0]  found;
    logic [4:0]  len;
  } list_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  req_type = '0;
  logic [15:0] position = '0;
  logic [31:0] item_data = '0;
  wire         busy;
  wire         done;
  wire  [1:0]  status;
  wire  [31:0] item_out;
  wire  [3:0]  found_position;
  wire  [4:0]  list_length;

  indexed_list_engine dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .position       (position),
    .item_data      (item_data),
    .done           (done),
    .status         (status),
    .item_out       (item_out),
    .found_position (found_position),
    .list_length    (list_length)
  );

  list_req_t   pending_reqs[$];
  list_resp_t  expected_resps[$];
  list_req_t   active_req;
  list_resp_t  want_resp;
  int          idle_left = 0;

  // Mirror of the list contents kept by the predictor.
  logic [31:0] shadow_list[LIST_DEPTH];
  int          shadow_len = 0;

  // Stimulus shaping state.
  int          gen_len = 0;
  int          calm_left = 0;
  logic [31:0] data_pool[8];

  int          error_count = 0;
  int          cycle_count = 0;
  int          words_done = 0;
  int          op_seen[8];
  int          full_seen = 0;
  int          miss_seen = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Take the entry at one index out of the mirror and close the gap.
  function automatic logic [31:0] take_at(int at);
    logic [31:0] taken;
    int i;
    taken = shadow_list[at];
    for (i = at; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_len--;
    return taken;
  endfunction

  // Predict the result of one request and update the mirror.
  function automatic list_resp_t list_outcome(list_req_t r);
    list_resp_t res;
    int at;
    int i;
    res.status = ile_pkg::ST_OK;
    res.item   = '0;
    res.found  = '0;
    case (r.op)
      ile_pkg::OP_APPEND, ile_pkg::OP_PUSH, ile_pkg::OP_INSERT: begin
        if (shadow_len >= LIST_DEPTH) begin
          res.status = ile_pkg::ST_FULL;
        end else begin
          if (r.op == ile_pkg::OP_APPEND) at = shadow_len;
          else if (r.op == ile_pkg::OP_PUSH) at = 0;
          else at = (int'(r.pos) >= shadow_len) ? shadow_len : int'(r.pos);
          for (i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[at] = r.data;
          shadow_len++;
        end
      end
      ile_pkg::OP_POP_TAIL: begin
        if (shadow_len == 0) res.status = ile_pkg::ST_MISS;
        else res.item = take_at(shadow_len - 1);
      end
      ile_pkg::OP_POP_HEAD: begin
        if (shadow_len == 0) res.status = ile_pkg::ST_MISS;
        else res.item = take_at(0);
      end
      ile_pkg::OP_REMOVE: begin
        if (int'(r.pos) >= shadow_len) res.status = ile_pkg::ST_MISS;
        else res.item = take_at(int'(r.pos));
      end
      ile_pkg::OP_FIND: begin
        res.status = ile_pkg::ST_MISS;
        for (i = 0; i < shadow_len; i++) begin
          if (res.status == ile_pkg::ST_MISS && shadow_list[i] == r.data) begin
            res.status = ile_pkg::ST_OK;
            res.found  = i[3:0];
          end
        end
      end
      default: begin
        shadow_len = 0;
      end
    endcase
    res.len = shadow_len[4:0];
    return res;
  endfunction

  // Queue one request word and track the length it leaves behind.
  task automatic add_req(ile_pkg::op_t op, logic [15:0] pos, logic [31:0] data);
    list_req_t r;
    r.op   = op;
    r.pos  = pos;
    r.data = data;
    if (calm_left > 0) begin
      r.gap = 0;
      calm_left--;
    end else begin
      r.gap = $urandom_range(0, 16);
    end
    pending_reqs.push_back(r);
    case (op)
      ile_pkg::OP_APPEND, ile_pkg::OP_PUSH, ile_pkg::OP_INSERT:
        if (gen_len < LIST_DEPTH) gen_len++;
      ile_pkg::OP_POP_TAIL, ile_pkg::OP_POP_HEAD:
        if (gen_len > 0) gen_len--;
      ile_pkg::OP_REMOVE:
        if (int'(pos) < gen_len) gen_len--;
      ile_pkg::OP_CLEAR:
        gen_len = 0;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_data();
    if ($urandom_range(0, 1) == 0) return data_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Positions mostly land near the live range, sometimes anywhere.
  function automatic logic [15:0] pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom_range(0, gen_len + 1));
    if (r == 7) return 16'd0;
    if (r == 8) return 16'(gen_len);
    return 16'($urandom);
  endfunction

  function automatic ile_pkg::op_t pick_taker();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) return ile_pkg::OP_POP_TAIL;
    if (r == 1) return ile_pkg::OP_POP_HEAD;
    return ile_pkg::OP_REMOVE;
  endfunction

  // Stimulus: directed corner cases, then random episodes.
  initial begin
    int directed_n;
    int mode;
    int n;
    int k;
    ile_pkg::op_t op;
    logic [15:0] pos;

    data_pool[0] = 32'h0000_0000;
    data_pool[1] = 32'hFFFF_FFFF;
    for (k = 2; k < 8; k++) data_pool[k] = $urandom;

    // Empty list corners, then build a short list and take it apart.
    add_req(ile_pkg::OP_CLEAR,    16'd0,      32'h0);
    add_req(ile_pkg::OP_POP_TAIL, 16'd0,      32'h0);
    add_req(ile_pkg::OP_POP_HEAD, 16'd0,      32'h0);
    add_req(ile_pkg::OP_REMOVE,   16'd0,      32'h0);
    add_req(ile_pkg::OP_REMOVE,   16'hFFFF,   32'h0);
    add_req(ile_pkg::OP_FIND,     16'd0,      32'h0);
    add_req(ile_pkg::OP_INSERT,   16'hFFFF,   32'hA5A5_A5A5);
    add_req(ile_pkg::OP_PUSH,     16'd0,      32'hFFFF_FFFF);
    add_req(ile_pkg::OP_APPEND,   16'd0,      32'h0000_0000);
    add_req(ile_pkg::OP_INSERT,   16'd0,      32'h1234_5678);
    add_req(ile_pkg::OP_INSERT,   16'd2,      32'h5A5A_5A5A);
    add_req(ile_pkg::OP_FIND,     16'hFFFF,   32'hFFFF_FFFF);
    add_req(ile_pkg::OP_FIND,     16'd0,      32'hDEAD_BEEF);
    add_req(ile_pkg::OP_APPEND,   16'd0,      32'hFFFF_FFFF);
    add_req(ile_pkg::OP_FIND,     16'd0,      32'hFFFF_FFFF);
    add_req(ile_pkg::OP_REMOVE,   16'd6,      32'h0);
    add_req(ile_pkg::OP_REMOVE,   16'd2,      32'h0);
    add_req(ile_pkg::OP_POP_HEAD, 16'd0,      32'h0);
    add_req(ile_pkg::OP_POP_TAIL, 16'd0,      32'h0);
    add_req(ile_pkg::OP_CLEAR,    16'h5555,   32'h0);
    directed_n = pending_reqs.size();

    while (pending_reqs.size() < directed_n + 1350) begin
      if ($urandom_range(0, 3) == 0) calm_left = $urandom_range(10, 60);
      mode = $urandom_range(0, 9);
      if (mode <= 2) begin
        // Fill to capacity, then push against the full list.
        while (gen_len < LIST_DEPTH) begin
          op = ile_pkg::op_t'($urandom_range(0, 2));
          if ($urandom_range(0, 7) == 0) add_req(ile_pkg::OP_FIND, pick_pos(), pick_data());
          else add_req(op, pick_pos(), pick_data());
        end
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++)
          add_req(ile_pkg::op_t'($urandom_range(0, 2)), pick_pos(), pick_data());
        add_req(ile_pkg::OP_FIND, pick_pos(), pick_data());
      end else if (mode <= 4) begin
        // Drain to empty, then take from the empty list.
        while (gen_len > 0) begin
          op = pick_taker();
          pos = (op == ile_pkg::OP_REMOVE) ? 16'($urandom_range(0, gen_len - 1)) : pick_pos();
          add_req(op, pos, pick_data());
        end
        n = $urandom_range(1, 2);
        for (k = 0; k < n; k++) add_req(pick_taker(), pick_pos(), pick_data());
      end else if (mode <= 7) begin
        n = $urandom_range(10, 30);
        for (k = 0; k < n; k++) begin
          op = ($urandom_range(0, 39) == 0) ? ile_pkg::OP_CLEAR
                                             : ile_pkg::op_t'($urandom_range(0, 6));
          add_req(op, pick_pos(), pick_data());
        end
      end else if (mode == 8) begin
        n = $urandom_range(5, 15);
        for (k = 0; k < n; k++) add_req(ile_pkg::OP_FIND, pick_pos(), pick_data());
      end else begin
        add_req(ile_pkg::OP_CLEAR, 16'($urandom), $urandom);
        n = $urandom_range(3, 10);
        for (k = 0; k < n; k++)
          add_req(ile_pkg::op_t'($urandom_range(0, 7)), 16'($urandom), $urandom);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to go out and every result to come back.
    while (pending_reqs.size() != 0 || start || expected_resps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d words: %0d append, %0d push, %0d insert, %0d pop tail, %0d pop head,",
             words_done, op_seen[ile_pkg::OP_APPEND], op_seen[ile_pkg::OP_PUSH],
             op_seen[ile_pkg::OP_INSERT], op_seen[ile_pkg::OP_POP_TAIL],
             op_seen[ile_pkg::OP_POP_HEAD]);
    $display("%0d remove, %0d find, %0d clear; %0d full refusals, %0d misses, %0d errors.",
             op_seen[ile_pkg::OP_REMOVE], op_seen[ile_pkg::OP_FIND],
             op_seen[ile_pkg::OP_CLEAR], full_seen, miss_seen, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Driver: present request words and predict each one as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left <= 0;
    end else if (start && !busy) begin
      want_resp = list_outcome(active_req);
      expected_resps.push_back(want_resp);
      op_seen[active_req.op]++;
      if (want_resp.status == ile_pkg::ST_FULL) full_seen++;
      if (want_resp.status == ile_pkg::ST_MISS) miss_seen++;
      if (pending_reqs.size() != 0 && pending_reqs[0].gap == 0) begin
        active_req = pending_reqs.pop_front();
        req_type  <= active_req.op;
        position  <= active_req.pos;
        item_data <= active_req.data;
      end else begin
        start <= 1'b0;
        idle_left <= (pending_reqs.size() != 0) ? pending_reqs[0].gap - 1 : 0;
      end
    end else if (!start && pending_reqs.size() != 0) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
      end else begin
        active_req = pending_reqs.pop_front();
        req_type  <= active_req.op;
        position  <= active_req.pos;
        item_data <= active_req.data;
        start     <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= SHOWN_MAX)
      $display("Mismatch on %s at word %0d: expected %0h, got %0h", field, words_done, want, got);
  endtask

  // Monitor: check each result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_resps.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_MAX)
          $display("Result word with nothing expected: status %0h, item %0h, length %0d",
                   status, item_out, list_length);
      end else begin
        list_resp_t want;
        want = expected_resps.pop_front();
        if (status !== want.status)         note_mismatch("status", want.status, status);
        if (item_out !== want.item)         note_mismatch("item_out", want.item, item_out);
        if (found_position !== want.found)  note_mismatch("found_position", want.found,
                                                          found_position);
        if (list_length !== want.len)       note_mismatch("list_length", want.len, list_length);
      end
      words_done++;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words queued and %0d results owed",
               cycle_count, pending_reqs.size(), expected_resps.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

[indexed_list_engine.f]
rtl/ile_pkg.sv
rtl/ile_cell.sv
rtl/indexed_list_engine.sv
test/testbench.sv
